[src/prb_pkg.sv]
// Shared types, constants and helpers of the port reservation bitmap.
package prb_pkg;

    // Store geometry
    localparam int PORT_COUNT = 65536;
    localparam int WORD_BITS  = 64;
    localparam int WORD_COUNT = (2 * PORT_COUNT) / WORD_BITS;
    localparam int HALF_COUNT = PORT_COUNT / WORD_BITS;
    localparam int ADDR_W     = $clog2(WORD_COUNT);
    localparam int POS_W      = $clog2(WORD_BITS);
    localparam int OFF_W      = $clog2(PORT_COUNT);

    // Fixed field widths
    localparam int PORT_W     = 16;
    localparam int PROTO_W    = 8;
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 2;

    localparam logic [ADDR_W-1:0] HALF_WORDS = ADDR_W'(HALF_COUNT);
    localparam logic [ADDR_W-1:0] LAST_WORD  = ADDR_W'(WORD_COUNT - 1);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_TEST      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND      = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DISABLED = 2'd2;

    // Protocol numbers
    localparam logic [PROTO_W-1:0] PROTO_TCP = 8'd6;
    localparam logic [PROTO_W-1:0] PROTO_UDP = 8'd17;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_BASE = 1'd1;

    // Queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic               family_is_ipv4;
        logic [PROTO_W-1:0] proto;
        logic [PORT_W-1:0]  port;
        logic [PORT_W-1:0]  marker;
        logic               from_start;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                hit;
        logic                found;
        logic [PORT_W-1:0]   found_offset;
    } t_result;

    typedef enum logic [2:0] {
        OP_REPORT,
        OP_TEST,
        OP_SET,
        OP_CLEAR,
        OP_CLEAR_ALL,
        OP_FIND
    } t_op;

    // A classified request as it waits for the back end.
    typedef struct packed {
        t_op                 op;
        logic [STATUS_W-1:0] status;
        logic                half;
        logic [ADDR_W-1:0]   addr;
        logic [POS_W-1:0]    pos;
    } t_job;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

    // Word address of an offset inside one protocol's half.
    function automatic logic [ADDR_W-1:0] word_addr(input logic half,
                                                    input logic [PORT_W:0] off);
        return (half ? HALF_WORDS : '0) + ADDR_W'(off >> POS_W);
    endfunction

endpackage

[src/prb_ram.sv]
// Generic simple dual-port RAM with registered read data.
module prb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/prb_front.sv]
// Front end: configuration registers and classification of incoming requests.
module prb_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  prb_pkg::t_cmd                  i_cmd,
    input  logic                           i_cfg_we,
    input  logic [prb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [prb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_push,
    output prb_pkg::t_job                  o_job
);
    import prb_pkg::*;

    logic              r_enabled;
    logic [PORT_W-1:0] r_port_base;

    logic            proto_ok;
    logic            is_udp;
    logic [PORT_W:0] diff;
    logic            in_window;
    logic [PORT_W:0] start;
    t_job            job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= 1'b1;
            r_port_base <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_ENABLED) begin
                r_enabled <= i_cfg_data[0];
            end
            if (i_cfg_idx == CFG_PORT_BASE) begin
                r_port_base <= i_cfg_data[PORT_W-1:0];
            end
        end
    end

    assign is_udp    = (i_cmd.proto == PROTO_UDP);
    assign proto_ok  = (i_cmd.proto == PROTO_TCP) || is_udp;
    assign diff      = {1'b0, i_cmd.port} - {1'b0, r_port_base};
    // The window is cut at the top of the port range on its own.
    assign in_window = !diff[PORT_W] && (diff < (PORT_W+1)'(PORT_COUNT));
    assign start     = i_cmd.from_start ? '0 : ({1'b0, i_cmd.marker} + 1'b1);

    always_comb begin
        job.op     = OP_REPORT;
        job.status = ST_DONE;
        job.half   = is_udp;
        job.addr   = '0;
        job.pos    = '0;
        if (!r_enabled) begin
            job.status = ST_DISABLED;
        end else begin
            case (i_cmd.command)
                CMD_TEST, CMD_SET, CMD_CLEAR: begin
                    if (i_cmd.family_is_ipv4 && proto_ok && in_window) begin
                        case (i_cmd.command)
                            CMD_TEST: job.op = OP_TEST;
                            CMD_SET:  job.op = OP_SET;
                            default:  job.op = OP_CLEAR;
                        endcase
                        job.addr = word_addr(is_udp, diff);
                        job.pos  = POS_W'(diff);
                    end else begin
                        job.status = ST_REJECT;
                    end
                end
                CMD_CLEAR_ALL: begin
                    job.op = OP_CLEAR_ALL;
                end
                CMD_FIND: begin
                    if (!proto_ok) begin
                        job.status = ST_REJECT;
                    end else if (start < (PORT_W+1)'(PORT_COUNT)) begin
                        job.op   = OP_FIND;
                        job.addr = word_addr(is_udp, start);
                        job.pos  = POS_W'(start);
                    end
                    // A start past the end of the half reports nothing found.
                end
                default: begin
                    job.status = ST_REJECT;
                end
            endcase
        end
    end

    assign o_push = i_accept;
    assign o_job  = job;

endmodule

[src/prb_fifo.sv]
// Short queue of classified requests between front and back ends.
module prb_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  prb_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output prb_pkg::t_job o_job
);
    import prb_pkg::*;

    t_job                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wptr;
    logic [FIFO_PTR_W-1:0] r_rptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];

endmodule

[src/prb_back.sv]
// Back end: carries out requests against the bitmap store and forms results.
module prb_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  prb_pkg::t_job       i_job,
    output logic                o_pop,
    output prb_pkg::t_back_stat o_stat,
    output logic                o_done,
    output prb_pkg::t_result    o_result
);
    import prb_pkg::*;

    typedef enum logic [4:0] {
        S_WIPE = 5'b00001,
        S_IDLE = 5'b00010,
        S_TEST = 5'b00100,
        S_RMW  = 5'b01000,
        S_SCAN = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    t_job              r_job, n_job;
    logic [ADDR_W-1:0] r_wipe_addr, n_wipe_addr;
    logic              r_wipe_cmd, n_wipe_cmd;
    logic [ADDR_W-1:0] r_scan_addr, n_scan_addr;
    logic [ADDR_W-1:0] r_data_addr, n_data_addr;
    logic              r_first, n_first;
    logic              r_done, n_done;
    t_result           r_result, n_result;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] masked;
    logic [WORD_BITS-1:0] lowest;
    logic [POS_W-1:0]     low_idx;
    logic [ADDR_W-1:0]    half_last;
    logic [ADDR_W-1:0]    addr_in_half;
    logic [OFF_W-1:0]     offset;

    prb_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << r_job.pos;

    // Only the first word of a search drops the bits below the start offset.
    assign masked = r_first ? (ram_rdata & ({WORD_BITS{1'b1}} << r_job.pos)) : ram_rdata;
    assign lowest = masked & (~masked + 1'b1);

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (lowest[i]) begin
                low_idx = low_idx | POS_W'(i);
            end
        end
    end

    assign half_last    = r_job.half ? LAST_WORD : (HALF_WORDS - 1'b1);
    assign addr_in_half = r_data_addr - (r_job.half ? HALF_WORDS : '0);
    assign offset       = OFF_W'({addr_in_half, low_idx});

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_wipe_addr = r_wipe_addr;
        n_wipe_cmd  = r_wipe_cmd;
        n_scan_addr = r_scan_addr;
        n_data_addr = r_data_addr;
        n_first     = r_first;
        n_done      = 1'b0;
        n_result    = '0;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_job.addr;
        ram_wdata   = '0;
        ram_raddr   = r_scan_addr;

        case (r_state)
            S_WIPE: begin
                ram_we      = 1'b1;
                ram_waddr   = r_wipe_addr;
                n_wipe_addr = r_wipe_addr + 1'b1;
                if (r_wipe_addr == LAST_WORD) begin
                    n_state = S_IDLE;
                    if (r_wipe_cmd) begin
                        n_done          = 1'b1;
                        n_result.status = ST_DONE;
                    end
                end
            end
            S_IDLE: begin
                ram_raddr = i_job.addr;
                if (i_job_valid) begin
                    o_pop = 1'b1;
                    n_job = i_job;
                    case (i_job.op)
                        OP_TEST: n_state = S_TEST;
                        OP_SET, OP_CLEAR: n_state = S_RMW;
                        OP_CLEAR_ALL: begin
                            n_state     = S_WIPE;
                            n_wipe_addr = '0;
                            n_wipe_cmd  = 1'b1;
                        end
                        OP_FIND: begin
                            n_state     = S_SCAN;
                            n_data_addr = i_job.addr;
                            n_scan_addr = i_job.addr + 1'b1;
                            n_first     = 1'b1;
                        end
                        default: begin
                            n_done          = 1'b1;
                            n_result.status = i_job.status;
                        end
                    endcase
                end
            end
            S_TEST: begin
                n_done       = 1'b1;
                n_result.hit = |(ram_rdata & bit_mask);
                n_state      = S_IDLE;
            end
            S_RMW: begin
                ram_we    = 1'b1;
                ram_wdata = (r_job.op == OP_SET) ? (ram_rdata | bit_mask)
                                                 : (ram_rdata & ~bit_mask);
                n_done    = 1'b1;
                n_state   = S_IDLE;
            end
            S_SCAN: begin
                // A read goes out every cycle; its data is looked at in the next cycle.
                n_first = 1'b0;
                if (masked != '0) begin
                    n_done                = 1'b1;
                    n_result.found        = 1'b1;
                    n_result.found_offset = PORT_W'(offset);
                    n_state               = S_IDLE;
                end else if (r_data_addr == half_last) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_data_addr = r_scan_addr;
                    n_scan_addr = r_scan_addr + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WIPE;
            r_wipe_addr <= '0;
            r_wipe_cmd  <= 1'b0;
            r_first     <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wipe_addr <= n_wipe_addr;
            r_wipe_cmd  <= n_wipe_cmd;
            r_first     <= n_first;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job       <= n_job;
        r_scan_addr <= n_scan_addr;
        r_data_addr <= n_data_addr;
        r_result    <= n_result;
    end

    // Only the pass after reset holds off new requests directly.
    assign o_stat.clearing = (r_state == S_WIPE) && !r_wipe_cmd;
    assign o_done          = r_done;
    assign o_result        = r_result;

endmodule

[src/port_reservation_bitmap.sv]
// Each accepted request gives one result strobe. Test, set and clear read the store, and
// set and clear write the word back; rejects and other requests are answered without the
// store; find next scans further 64-bit words, one word per cycle; clear all wipes the
// whole store. The back end carries out one request at a time while the queue ahead of it
// takes further requests until it is full; the receiver never stalls.
// Reset: synchronous; afterwards the whole store is wiped with busy high.
module port_reservation_bitmap (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  prb_pkg::t_cmd                  i_cmd,
    input  logic                           i_cfg_we,
    input  logic [prb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [prb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_busy,
    output logic                           o_done,
    output prb_pkg::t_result               o_result
);
    import prb_pkg::*;

    logic       accept;
    logic       push;
    t_job       front_job;
    logic       fifo_full;
    logic       fifo_valid;
    t_job       fifo_job;
    logic       pop;
    t_back_stat back_stat;

    assign o_busy = fifo_full || back_stat.clearing;
    assign accept = i_start && !o_busy;

    prb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (push),
        .o_job      (front_job)
    );

    prb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (fifo_full),
        .o_valid (fifo_valid),
        .o_job   (fifo_job)
    );

    prb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (fifo_valid),
        .i_job       (fifo_job),
        .o_pop       (pop),
        .o_stat      (back_stat),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule

[src/prb_checker.sv]
// Port-level checks of the port reservation bitmap and their binding.
module prb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_start,
    input prb_pkg::t_cmd                  i_cmd,
    input logic                           i_cfg_we,
    input logic [prb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [prb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                           o_busy,
    input logic                           o_done,
    input prb_pkg::t_result               o_result
);
    import prb_pkg::*;

    // The store wipe after reset must hold off requests.
    a_busy_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_busy)
        else $error("not busy right after reset");

    a_no_done_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.status == ST_DONE || o_result.status == ST_REJECT ||
                    o_result.status == ST_DISABLED))
        else $error("status code out of range");

    a_fail_is_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status != ST_DONE |->
            !o_result.hit && !o_result.found && o_result.found_offset == '0)
        else $error("rejected request carries a payload");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_result.hit && o_result.found) &&
                   (o_result.found || o_result.found_offset == '0))
        else $error("result mixes test and search fields");

endmodule

bind port_reservation_bitmap prb_checker u_checker (.*);
